// ===== rtl/btff_pkg.sv =====
// ----------------------------------------------------------------------------
// btff_pkg
// Types and fixed constants of the boundary-tag first-fit heap allocator.
// ----------------------------------------------------------------------------
package btff_pkg;

  // One request: kind 0 allocates, kind 1 frees
  typedef struct packed {
    logic        kind;
    logic [16:0] request_bytes;
    logic [15:0] block_offset;
  } in_t;

  // One answer
  typedef struct packed {
    logic        granted;
    logic [15:0] payload_offset;
  } out_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned DWORD_BYTES = 8;
  localparam int unsigned MIN_BLOCK   = 16;
  localparam int unsigned FIRST_BP    = 8;
  // Prologue tag: size 8 with the allocated bit
  localparam logic [31:0] PROLOGUE_TAG = 32'h0000_0009;
  localparam logic [31:0] EPILOGUE_TAG = 32'h0000_0001;

endpackage

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// Heap allocator with header/footer boundary tags and first-fit search.
// ----------------------------------------------------------------------------
// Start a transfer by raising start while busy is low; busy stays high until
// the answer has been produced, and the answer appears on out_data for one
// cycle with out_valid, which the receiver cannot hold off. Every access to
// the heap goes through a single word store with one read and one write per
// cycle, so an item reads one header per block visited on the list, then
// grows, merges and writes tags, and its answer passes through the result
// register (a free likewise walks the list up to its block). After reset
// the block writes the prologue, the first chunk if it fits in the heap,
// and the epilogue; words past the break are always written before they are
// read, so no clearing pass runs.
module boundary_tag_first_fit_allocator
  import btff_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = 65536,
  parameter int unsigned CHUNK_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  localparam int unsigned AW = $clog2(HEAP_BYTES / 4);

  logic          done;
  out_t          result;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          out_valid_r;
  out_t          out_data_r;

  btff_ctrl #(
    .HEAP_BYTES (HEAP_BYTES),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  btff_mem #(
    .DEPTH(HEAP_BYTES / 4),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Result register: one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
    out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still working");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.granted) |-> (out_data.payload_offset == '0))
    else $error("failed answer carries an offset");

endmodule

// ===== rtl/btff_mem.sv =====
// ----------------------------------------------------------------------------
// btff_mem
// Heap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btff_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule

// ===== rtl/btff_ctrl.sv =====
// ----------------------------------------------------------------------------
// btff_ctrl
// Sequencer: walks the block list, grows the break, merges and splits blocks
// by reading tags from the heap store and queuing tag writes.
// ----------------------------------------------------------------------------
module btff_ctrl
  import btff_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = 65536,
  parameter int unsigned CHUNK_BYTES = 4096
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  in_t   in_data,
  output logic  busy,
  output logic  done,
  output out_t  result,
  // heap store port
  output logic                              mem_we,
  output logic [$clog2(HEAP_BYTES/4)-1:0]   mem_waddr,
  output logic [31:0]                       mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(HEAP_BYTES/4)-1:0]   mem_raddr,
  input  logic [31:0]                       mem_rdata
);

  localparam int unsigned AW   = $clog2(HEAP_BYTES / 4);
  localparam int unsigned LB   = $clog2(HEAP_BYTES);
  // byte quantities: room for heap size, 17-bit requests and one carry
  localparam int unsigned OW   = ((LB > 17) ? LB : 17) + 2;
  localparam int unsigned CHUNK_R = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
  localparam bit          FITS    = (16 + CHUNK_R <= HEAP_BYTES);
  localparam int unsigned QN   = 5;
  localparam int unsigned QW   = $clog2(QN);

  localparam logic [OW-1:0] HEAP_C  = OW'(HEAP_BYTES);
  localparam logic [OW-1:0] CHUNK_C = OW'(CHUNK_BYTES);
  localparam logic [OW-1:0] CHRND_C = OW'(CHUNK_R);
  localparam logic [OW-1:0] W4      = OW'(WORD_BYTES);
  localparam logic [OW-1:0] W8      = OW'(DWORD_BYTES);
  localparam logic [OW-1:0] MINB    = OW'(MIN_BLOCK);
  localparam logic [OW-1:0] FBP     = OW'(FIRST_BP);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_WALKD  = 4'd3;
  localparam logic [3:0] S_GROW   = 4'd4;
  localparam logic [3:0] S_MPREV  = 4'd5;
  localparam logic [3:0] S_MPREVD = 4'd6;
  localparam logic [3:0] S_MNEXTD = 4'd7;
  localparam logic [3:0] S_MPHD   = 4'd8;
  localparam logic [3:0] S_CARVE  = 4'd9;
  localparam logic [3:0] S_WR     = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic          kind_r, kind_nxt;
  logic [OW-1:0] asize_r, asize_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [OW-1:0] bp_r, bp_nxt;
  logic [OW-1:0] size_r, size_nxt;
  logic [OW-1:0] brk_r, brk_nxt;
  logic          pa_r, pa_nxt, na_r, na_nxt;
  logic [OW-1:0] psize_r, psize_nxt, nsize_r, nsize_nxt;
  logic          gnt_r, gnt_nxt;
  logic [15:0]   pay_r, pay_nxt;
  logic [OW-1:0] wq_a_r [QN];
  logic [OW-1:0] wq_a_nxt [QN];
  logic [31:0]   wq_d_r [QN];
  logic [31:0]   wq_d_nxt [QN];
  logic [QW-1:0] wcnt_r, wcnt_nxt, widx_r, widx_nxt;
  logic          roob_r;

  logic [OW-1:0] rd_addr;
  logic [OW-1:0] wr_addr;
  logic [31:0]   rword;
  logic [OW-1:0] tsz;
  logic          tal;
  logic [OW-1:0] gsize, rest, req_x;

  // Tag fields of the word just read; reads past the store give 0
  assign rword = roob_r ? 32'd0 : mem_rdata;
  assign tsz   = {rword[OW-1:3], 3'b000};
  assign tal   = rword[0];

  assign req_x = OW'(in_data.request_bytes);
  assign gsize = (asize_r > CHUNK_C) ? asize_r : CHRND_C;
  assign rest  = size_r - asize_r;

  // Store ports
  assign wr_addr   = wq_a_r[widx_r];
  assign mem_we    = (state_r == S_WR) && (wr_addr < HEAP_C);
  assign mem_waddr = wr_addr[AW+1:2];
  assign mem_wdata = wq_d_r[widx_r];
  assign mem_raddr = rd_addr[AW+1:2];

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign result = '{granted: gnt_r, payload_offset: pay_r};

  // Next-state and datapath
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    kind_nxt  = kind_r;
    asize_nxt = asize_r;
    off_nxt   = off_r;
    bp_nxt    = bp_r;
    size_nxt  = size_r;
    brk_nxt   = brk_r;
    pa_nxt    = pa_r;
    na_nxt    = na_r;
    psize_nxt = psize_r;
    nsize_nxt = nsize_r;
    gnt_nxt   = gnt_r;
    pay_nxt   = pay_r;
    wq_a_nxt  = wq_a_r;
    wq_d_nxt  = wq_d_r;
    wcnt_nxt  = wcnt_r;
    widx_nxt  = widx_r;
    mem_re    = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      S_INIT: begin
        wq_a_nxt[0] = OW'(4);
        wq_d_nxt[0] = PROLOGUE_TAG;
        wq_a_nxt[1] = OW'(8);
        wq_d_nxt[1] = PROLOGUE_TAG;
        if (FITS) begin
          wq_a_nxt[2] = OW'(12);
          wq_d_nxt[2] = 32'(CHRND_C);
          wq_a_nxt[3] = OW'(16) + CHRND_C - W8;
          wq_d_nxt[3] = 32'(CHRND_C);
          wq_a_nxt[4] = OW'(16) + CHRND_C - W4;
          wq_d_nxt[4] = EPILOGUE_TAG;
          wcnt_nxt    = QW'(5);
          brk_nxt     = OW'(16) + CHRND_C;
        end else begin
          wq_a_nxt[2] = OW'(12);
          wq_d_nxt[2] = EPILOGUE_TAG;
          wcnt_nxt    = QW'(3);
          brk_nxt     = OW'(16);
        end
        widx_nxt  = '0;
        ret_nxt   = S_IDLE;
        state_nxt = S_WR;
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_data.kind;
          off_nxt  = in_data.block_offset;
          bp_nxt   = FBP;
          gnt_nxt  = 1'b0;
          pay_nxt  = '0;
          if (in_data.kind == KIND_ALLOC && in_data.request_bytes == '0) begin
            state_nxt = S_DONE;
          end else begin
            // payload rounded up to 8 bytes plus 8 bytes of tags
            asize_nxt = (req_x <= W8) ? MINB
                      : ((req_x + OW'(15)) & ~OW'(7));
            state_nxt = S_WALK;
          end
        end
      end
      // Walk the implicit list: one header read per block
      S_WALK: begin
        if (bp_r < brk_r && (kind_r == KIND_ALLOC || bp_r <= OW'(off_r))) begin
          mem_re    = 1'b1;
          rd_addr   = bp_r - W4;
          state_nxt = S_WALKD;
        end else if (kind_r == KIND_ALLOC) begin
          state_nxt = S_GROW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALKD: begin
        if (kind_r == KIND_ALLOC) begin
          if (tsz == '0) begin
            state_nxt = S_GROW;
          end else if (!tal && asize_r <= tsz) begin
            size_nxt  = tsz;
            state_nxt = S_CARVE;
          end else begin
            bp_nxt    = bp_r + tsz;
            state_nxt = S_WALK;
          end
        end else begin
          if (tsz == '0) begin
            state_nxt = S_DONE;
          end else if (bp_r == OW'(off_r)) begin
            if (bp_r != FBP && tal) begin
              // clear the allocated bit, then merge
              size_nxt    = tsz;
              wq_a_nxt[0] = bp_r - W4;
              wq_d_nxt[0] = 32'(tsz);
              wq_a_nxt[1] = bp_r + tsz - W8;
              wq_d_nxt[1] = 32'(tsz);
              wcnt_nxt    = QW'(2);
              widx_nxt    = '0;
              gnt_nxt     = 1'b1;
              ret_nxt     = S_MPREV;
              state_nxt   = S_WR;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            bp_nxt    = bp_r + tsz;
            state_nxt = S_WALK;
          end
        end
      end
      // Extend the break with a new free block and a new epilogue
      S_GROW: begin
        if (brk_r + gsize > HEAP_C) begin
          state_nxt = S_DONE;
        end else begin
          bp_nxt      = brk_r;
          size_nxt    = gsize;
          brk_nxt     = brk_r + gsize;
          wq_a_nxt[0] = brk_r - W4;
          wq_d_nxt[0] = 32'(gsize);
          wq_a_nxt[1] = brk_r + gsize - W8;
          wq_d_nxt[1] = 32'(gsize);
          wq_a_nxt[2] = brk_r + gsize - W4;
          wq_d_nxt[2] = EPILOGUE_TAG;
          wcnt_nxt    = QW'(3);
          widx_nxt    = '0;
          ret_nxt     = S_MPREV;
          state_nxt   = S_WR;
        end
      end
      // Merge: previous footer, next header, previous header
      S_MPREV: begin
        mem_re    = 1'b1;
        rd_addr   = bp_r - W8;
        state_nxt = S_MPREVD;
      end
      S_MPREVD: begin
        pa_nxt    = tal;
        psize_nxt = tsz;
        mem_re    = 1'b1;
        rd_addr   = bp_r + size_r - W4;
        state_nxt = S_MNEXTD;
      end
      S_MNEXTD: begin
        na_nxt    = tal;
        nsize_nxt = tsz;
        mem_re    = 1'b1;
        rd_addr   = bp_r - psize_r - W4;
        state_nxt = S_MPHD;
      end
      S_MPHD: begin
        priority if (pa_r && na_r) begin
          state_nxt = (kind_r == KIND_ALLOC) ? S_CARVE : S_DONE;
        end else begin
          if (pa_r) begin
            size_nxt = size_r + nsize_r;
          end else if (na_r) begin
            bp_nxt   = bp_r - psize_r;
            size_nxt = size_r + tsz;
          end else begin
            bp_nxt   = bp_r - psize_r;
            size_nxt = size_r + tsz + nsize_r;
          end
          wq_a_nxt[0] = bp_nxt - W4;
          wq_d_nxt[0] = 32'(size_nxt);
          wq_a_nxt[1] = bp_nxt + size_nxt - W8;
          wq_d_nxt[1] = 32'(size_nxt);
          wcnt_nxt    = QW'(2);
          widx_nxt    = '0;
          ret_nxt     = (kind_r == KIND_ALLOC) ? S_CARVE : S_DONE;
          state_nxt   = S_WR;
        end
      end
      // Mark the block allocated, splitting off a free remainder of at least MIN_BLOCK
      S_CARVE: begin
        gnt_nxt  = 1'b1;
        pay_nxt  = bp_r[15:0];
        widx_nxt = '0;
        ret_nxt  = S_DONE;
        if (rest < MINB) begin
          wq_a_nxt[0] = bp_r - W4;
          wq_d_nxt[0] = 32'(size_r) | EPILOGUE_TAG;
          wq_a_nxt[1] = bp_r + size_r - W8;
          wq_d_nxt[1] = 32'(size_r) | EPILOGUE_TAG;
          wcnt_nxt    = QW'(2);
        end else begin
          wq_a_nxt[0] = bp_r - W4;
          wq_d_nxt[0] = 32'(asize_r) | EPILOGUE_TAG;
          wq_a_nxt[1] = bp_r + asize_r - W8;
          wq_d_nxt[1] = 32'(asize_r) | EPILOGUE_TAG;
          wq_a_nxt[2] = bp_r + asize_r - W4;
          wq_d_nxt[2] = 32'(rest);
          wq_a_nxt[3] = bp_r + size_r - W8;
          wq_d_nxt[3] = 32'(rest);
          wcnt_nxt    = QW'(4);
        end
        state_nxt = S_WR;
      end
      // Drain queued tag writes, one per cycle
      S_WR: begin
        widx_nxt = widx_r + QW'(1);
        if (widx_r == wcnt_r - QW'(1)) begin
          state_nxt = ret_r;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    kind_r  <= kind_nxt;
    asize_r <= asize_nxt;
    off_r   <= off_nxt;
    bp_r    <= bp_nxt;
    size_r  <= size_nxt;
    brk_r   <= brk_nxt;
    pa_r    <= pa_nxt;
    na_r    <= na_nxt;
    psize_r <= psize_nxt;
    nsize_r <= nsize_nxt;
    gnt_r   <= gnt_nxt;
    pay_r   <= pay_nxt;
    wq_a_r  <= wq_a_nxt;
    wq_d_r  <= wq_d_nxt;
    wcnt_r  <= wcnt_nxt;
    widx_r  <= widx_nxt;
    roob_r  <= (rd_addr >= HEAP_C);
  end

endmodule
